@@ src/brl_pkg.sv @@
// shared types and constants for the bounded random (lemire) unit
// no dependencies
package brl_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned Depth = 32;
  typedef logic [WordW-1:0] word_t;

  // one restoring-division cell's payload
  typedef struct packed {
    logic  valid;
    logic  bad;
    word_t limit;
    word_t rem;
    word_t dividend;
    word_t prod_lo;
    word_t prod_hi;
  } cell_t;
endpackage

@@ src/brl_cell.sv @@
// one step of the restoring remainder chain for (2^32 - limit) mod limit
// depends on brl_pkg
module brl_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  brl_pkg::cell_t din,
  output brl_pkg::cell_t dout
);
  logic [brl_pkg::WordW:0] trial;
  logic [brl_pkg::WordW:0] diff;
  brl_pkg::cell_t          nxt;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {din.rem, din.dividend[brl_pkg::WordW-1]};
    diff  = trial - {1'b0, din.limit};
    nxt   = din;
    nxt.dividend = {din.dividend[brl_pkg::WordW-2:0], 1'b0};
    if (!diff[brl_pkg::WordW]) begin
      nxt.rem = diff[brl_pkg::WordW-1:0];
    end else begin
      nxt.rem = trial[brl_pkg::WordW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= din.valid;
    end
    if (adv) begin
      dout.bad      <= nxt.bad;
      dout.limit    <= nxt.limit;
      dout.rem      <= nxt.rem;
      dout.dividend <= nxt.dividend;
      dout.prod_lo  <= nxt.prod_lo;
      dout.prod_hi  <= nxt.prod_hi;
    end
  end
endmodule

@@ src/bounded_random_lemire_unit.sv @@
// top level of the lemire bounded random unit
// depends on brl_pkg and brl_cell
// Takes one (limit, random_word) transaction per cycle unless stalled and
// returns one result per transaction in order. After its input is accepted,
// the entry register captures the 32x32 product, a row of 32 remainder cells
// computes the threshold one quotient bit per cell, and the output register
// compares and holds the result.
// The whole row advances together whenever the output register is free or
// being taken, so throughput is one transaction per cycle under no stall.
// tdata in: limit [31:0], random_word [63:32]
// tdata out: value [31:0]; tuser out: accepted [0], bad_limit [1]
module bounded_random_lemire_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // limit, random_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // value
  output logic [1:0]  m_tuser    // accepted, bad_limit
);
  logic                adv;
  brl_pkg::cell_t      chain [brl_pkg::Depth+1];
  logic [63:0]         prod;
  brl_pkg::word_t      lim_in;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign lim_in   = s_tdata[31:0];
  assign prod     = {32'd0, s_tdata[63:32]} * {32'd0, lim_in};

  // entry stage: product register and remainder chain seed
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= s_tvalid;
    end
    if (adv) begin
      chain[0].bad      <= (lim_in == '0);
      chain[0].limit    <= lim_in;
      chain[0].rem      <= '0;
      chain[0].dividend <= 32'd0 - lim_in;
      chain[0].prod_lo  <= prod[31:0];
      chain[0].prod_hi  <= prod[63:32];
    end
  end

  // row of remainder cells
  for (genvar i = 0; i < brl_pkg::Depth; i++) begin : g_cell
    brl_cell u_cell (
      .clk (clk),
      .rst (rst),
      .adv (adv),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  // compare and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= chain[brl_pkg::Depth].valid;
    end
    if (adv) begin
      if (chain[brl_pkg::Depth].bad) begin
        m_tdata <= '0;
        m_tuser <= 2'b10;
      end else begin
        m_tdata <= chain[brl_pkg::Depth].prod_hi;
        m_tuser <= {1'b0,
                    chain[brl_pkg::Depth].prod_lo >= chain[brl_pkg::Depth].rem};
      end
    end
  end

  // output never both accepted and flagged bad
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1])) else $error("accepted with bad limit");
  // accepted value lies below the limit carried with it
  a_range: assert property (@(posedge clk) disable iff (rst)
    (adv && chain[brl_pkg::Depth].valid && !chain[brl_pkg::Depth].bad &&
     chain[brl_pkg::Depth].prod_lo >= chain[brl_pkg::Depth].rem)
    |-> chain[brl_pkg::Depth].prod_hi < chain[brl_pkg::Depth].limit)
    else $error("value out of range");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
endmodule
